@@ sv/smm_pkg.sv @@
// ----------------------------------------------------------------------------
// Shape measurement merge package
// Transaction types and fixed constants shared by the merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // Components of one parameter vector: centre xyz, axis xyz, radius
  localparam int unsigned NCOMP = 7;

  // Highest merge count; further merges keep the divisor at COUNT_MAX + 1
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // Merge threshold after reset, Q3.12 metres
  localparam logic [15:0] MATCH_RESET = 16'd205;

  // Command codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_FLUSH   = 1'b1;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    logic        command;
    logic        is_cylinder;
    coord_t      base_x;
    coord_t      base_y;
    coord_t      base_z;
    coord_t      axis_x;
    coord_t      axis_y;
    coord_t      axis_z;
    logic [14:0] radius;
  } smm_in_t;

  typedef struct packed {
    logic        out_is_cylinder;
    coord_t      mean_x;
    coord_t      mean_y;
    coord_t      mean_z;
    coord_t      mean_axis_x;
    coord_t      mean_axis_y;
    coord_t      mean_axis_z;
    logic [14:0] mean_radius;
    logic [7:0]  merge_count;
    logic        last_entry;
  } smm_out_t;

endpackage

`default_nettype wire

@@ sv/shape_measurement_merge.sv @@
// ----------------------------------------------------------------------------
// Shape measurement merge
// Merges cylinder and sphere measurements of one frame into running means
// and emits the merged entries on an end-of-frame command.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------
//  in      | input     | in_valid_i / in_ready_o    | smm_pkg::smm_in_t
//  out     | output    | out_valid_o / out_ready_i  | smm_pkg::smm_out_t
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | match_distance
//
//  A measurement visits each stored entry of its kind in turn (one more step when
//  nothing matches) and runs a distance check per entry (one 17x17 multiply per
//  component through the shared multiplier), up to two checks per entry.
//  A merge folds each component in turn through the shared radix-2 divider.
//  End of frame emits each stored entry in turn, cylinders first, waiting out output stalls.
//  Reset clears the entry counts and restores the threshold; no clearing pass.
//  The input and the threshold write are held off for the whole of one
//  transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module shape_measurement_merge #(
  parameter int unsigned TABLE_DEPTH = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire smm_pkg::smm_in_t  in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      smm_pkg::smm_out_t out_data_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [15:0]       cfg_data_i
);

  localparam int unsigned JW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NEXT  = 4'd1;
  localparam logic [3:0] S_DIST  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_FSET  = 4'd4;
  localparam logic [3:0] S_FDIV  = 4'd5;
  localparam logic [3:0] S_FWB   = 4'd6;
  localparam logic [3:0] S_ESEL  = 4'd7;
  localparam logic [3:0] S_EOUT  = 4'd8;

  localparam logic [2:0] K_LAST = 3'(smm_pkg::NCOMP);

  // Control state
  logic [3:0]    state_q, state_d;
  logic          kind_q, kind_d;
  logic          orient_q, orient_d;
  logic [JW-1:0] j_q, j_d;
  logic [2:0]    k_q, k_d;
  logic [4:0]    bc_q, bc_d;
  logic [JW-1:0] used_q [2];
  logic [7:0]    cnt_q [2][TABLE_DEPTH];
  logic [31:0]   lim_q;

  // Datapath registers
  smm_pkg::coord_t m_q [smm_pkg::NCOMP];
  logic [33:0]     prod_q, prod_d;
  logic [35:0]     sum_q, sum_d;
  logic [8:0]      rem_q, rem_d;
  logic [16:0]     quo_q, quo_d;
  logic            neg_q, neg_d;
  logic [8:0]      div_q, div_d;
  smm_pkg::smm_out_t out_q;
  smm_pkg::coord_t mean_q [2][TABLE_DEPTH][smm_pkg::NCOMP];

  // Strobes
  logic load_m, open_we, fold_we, cnt_inc, load_out, clear_all;

  // Measurement vector for an accepted transaction
  smm_pkg::coord_t m_new [smm_pkg::NCOMP];
  logic signed [16:0] ctr_sum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ctr_sum[c] = 17'sd0;
    end
    ctr_sum[0] = {in_data_i.base_x[15], in_data_i.base_x}
               + {{2{in_data_i.axis_x[15]}}, in_data_i.axis_x[15:1]};
    ctr_sum[1] = {in_data_i.base_y[15], in_data_i.base_y}
               + {{2{in_data_i.axis_y[15]}}, in_data_i.axis_y[15:1]};
    ctr_sum[2] = {in_data_i.base_z[15], in_data_i.base_z}
               + {{2{in_data_i.axis_z[15]}}, in_data_i.axis_z[15:1]};
    if (in_data_i.is_cylinder) begin
      for (int c = 0; c < 3; c++) begin
        if (ctr_sum[c][16] != ctr_sum[c][15]) begin
          m_new[c] = ctr_sum[c][16] ? 16'sh8000 : 16'sh7fff;
        end else begin
          m_new[c] = ctr_sum[c][15:0];
        end
      end
      m_new[3] = in_data_i.axis_x;
      m_new[4] = in_data_i.axis_y;
      m_new[5] = in_data_i.axis_z;
    end else begin
      m_new[0] = in_data_i.base_x;
      m_new[1] = in_data_i.base_y;
      m_new[2] = in_data_i.base_z;
      m_new[3] = 16'sd0;
      m_new[4] = 16'sd0;
      m_new[5] = 16'sd0;
    end
    m_new[6] = {1'b0, in_data_i.radius};
  end

  // Component under test, with the axis flipped on the second orientation
  logic [2:0]         kidx;
  logic [IW-1:0]      eidx;
  smm_pkg::coord_t    vcur, ecur;
  logic signed [16:0] diff, absd;
  logic               is_axis;

  assign kidx    = (k_q == K_LAST) ? 3'd0 : k_q;
  assign eidx    = j_q[IW-1:0];
  assign is_axis = (k_q == 3'd3) || (k_q == 3'd4) || (k_q == 3'd5);
  assign ecur    = mean_q[kind_q][eidx][kidx];

  always_comb begin
    vcur = m_q[kidx];
    if (orient_q && is_axis) begin
      vcur = (m_q[kidx] == 16'sh8000) ? 16'sh7fff : -m_q[kidx];
    end
  end

  assign diff = {vcur[15], vcur} - {ecur[15], ecur};
  assign absd = diff[16] ? -diff : diff;

  // Divider step: one quotient bit a cycle
  logic [9:0] trial;
  assign trial = {rem_q, quo_q[16]};

  // Folded component
  logic signed [17:0] qs, newv;
  assign qs   = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
  assign newv = {{2{ecur[15]}}, ecur} + qs;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    orient_d  = orient_q;
    j_d       = j_q;
    k_d       = k_q;
    bc_d      = bc_q;
    prod_d    = prod_q;
    sum_d     = sum_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    neg_d     = neg_q;
    div_d     = div_q;
    load_m    = 1'b0;
    open_we   = 1'b0;
    fold_we   = 1'b0;
    cnt_inc   = 1'b0;
    load_out  = 1'b0;
    clear_all = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          j_d      = '0;
          orient_d = 1'b0;
          if (in_data_i.command == smm_pkg::CMD_FLUSH) begin
            kind_d  = 1'b1;
            state_d = S_ESEL;
          end else begin
            kind_d  = in_data_i.is_cylinder;
            load_m  = 1'b1;
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (j_q < used_q[kind_q]) begin
          k_d     = '0;
          sum_d   = '0;
          state_d = S_DIST;
        end else begin
          open_we = (used_q[kind_q] < JW'(TABLE_DEPTH));
          state_d = S_IDLE;
        end
      end
      S_DIST: begin
        // Square one component while the previous square accumulates
        if (k_q != K_LAST) begin
          prod_d = 34'(diff * diff);
        end
        if (k_q != 3'd0) begin
          sum_d = sum_q + 36'(prod_q);
        end
        k_d = k_q + 3'd1;
        if (k_q == K_LAST) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sum_q < 36'(lim_q)) begin
          k_d     = '0;
          div_d   = {1'b0, cnt_q[kind_q][eidx]} + 9'd1;
          state_d = S_FSET;
        end else if (kind_q && !orient_q) begin
          orient_d = 1'b1;
          k_d      = '0;
          sum_d    = '0;
          state_d  = S_DIST;
        end else begin
          orient_d = 1'b0;
          j_d      = j_q + JW'(1);
          state_d  = S_NEXT;
        end
      end
      S_FSET: begin
        neg_d   = diff[16];
        quo_d   = absd + 17'(div_q[8:1]);
        rem_d   = '0;
        bc_d    = '0;
        state_d = S_FDIV;
      end
      S_FDIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = 9'(trial - {1'b0, div_q});
          quo_d = {quo_q[15:0], 1'b1};
        end else begin
          rem_d = trial[8:0];
          quo_d = {quo_q[15:0], 1'b0};
        end
        bc_d = bc_q + 5'd1;
        if (bc_q == 5'd16) begin
          state_d = S_FWB;
        end
      end
      S_FWB: begin
        fold_we = 1'b1;
        if (k_q == K_LAST - 3'd1) begin
          cnt_inc = 1'b1;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_FSET;
        end
      end
      S_ESEL: begin
        if (j_q < used_q[kind_q]) begin
          load_out = 1'b1;
          state_d  = S_EOUT;
        end else if (kind_q) begin
          kind_d = 1'b0;
          j_d    = '0;
        end else begin
          clear_all = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_EOUT: begin
        if (out_ready_i) begin
          j_d     = j_q + JW'(1);
          state_d = S_ESEL;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= 1'b0;
      orient_q <= 1'b0;
      j_q      <= '0;
      k_q      <= '0;
      bc_q     <= '0;
      used_q   <= '{default: '0};
      cnt_q    <= '{default: '0};
      lim_q    <= 32'(smm_pkg::MATCH_RESET * smm_pkg::MATCH_RESET);
    end else begin
      state_q  <= state_d;
      kind_q   <= kind_d;
      orient_q <= orient_d;
      j_q      <= j_d;
      k_q      <= k_d;
      bc_q     <= bc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        lim_q <= cfg_data_i * cfg_data_i;
      end
      if (open_we) begin
        cnt_q[kind_q][used_q[kind_q][IW-1:0]] <= 8'd1;
        used_q[kind_q] <= used_q[kind_q] + JW'(1);
      end
      if (cnt_inc && (cnt_q[kind_q][eidx] != smm_pkg::COUNT_MAX)) begin
        cnt_q[kind_q][eidx] <= cnt_q[kind_q][eidx] + 8'd1;
      end
      if (clear_all) begin
        used_q <= '{default: '0};
        cnt_q  <= '{default: '0};
      end
    end
  end

  // Hold datapath values and the tables
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sum_q  <= sum_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    neg_q  <= neg_d;
    div_q  <= div_d;
    if (load_m) begin
      m_q <= m_new;
    end
    if (open_we) begin
      mean_q[kind_q][used_q[kind_q][IW-1:0]] <= m_q;
    end
    if (fold_we) begin
      mean_q[kind_q][eidx][kidx] <= newv[15:0];
    end
    if (load_out) begin
      out_q.out_is_cylinder <= kind_q;
      out_q.mean_x          <= mean_q[kind_q][eidx][0];
      out_q.mean_y          <= mean_q[kind_q][eidx][1];
      out_q.mean_z          <= mean_q[kind_q][eidx][2];
      out_q.mean_axis_x     <= mean_q[kind_q][eidx][3];
      out_q.mean_axis_y     <= mean_q[kind_q][eidx][4];
      out_q.mean_axis_z     <= mean_q[kind_q][eidx][5];
      out_q.mean_radius     <= mean_q[kind_q][eidx][6][14:0];
      out_q.merge_count     <= cnt_q[kind_q][eidx];
      out_q.last_entry      <= ((j_q + JW'(1)) == used_q[kind_q])
                               && (!kind_q || (used_q[0] == '0));
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EOUT);
  assign out_data_o  = out_q;
  assign cfg_ready_o = (state_q == S_IDLE);

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("output offered while input accepted");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q[0] <= JW'(TABLE_DEPTH)) && (used_q[1] <= JW'(TABLE_DEPTH)))
    else $error("entry count beyond table depth");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FSET) |-> (div_q != 9'd0))
    else $error("zero divisor at merge");

endmodule

`default_nettype wire
